@@ design/p2c_pkg.sv @@
`default_nettype none

package p2c_pkg;

  localparam int unsigned DATA_W     = 32;
  // Cells in the modulo-360 chain: each takes off one multiple of a full turn.
  localparam int unsigned RED_CELLS  = 7;
  localparam int unsigned RED_IDX_W  = 3;
  // Rotation cells and the width of their stage index.
  localparam int unsigned ROT_STAGES = 18;
  localparam int unsigned ROT_IDX_W  = 5;
  // Two angle lanes ride through the rotation chain.
  localparam int unsigned LANES      = 2;
  localparam int unsigned LANE_TH    = 0;
  localparam int unsigned LANE_PH    = 1;
  localparam int unsigned ATAN_W     = 30;

  // 360 degrees in Q16.16.
  localparam logic [DATA_W-1:0] TURN_Q16 = 32'd23592960;
  // Inverse rotation gain in Q2.30.
  localparam logic signed [DATA_W-1:0] GAIN_INV = 32'sd652032874;

  typedef struct packed {
    logic signed [DATA_W-1:0] len;
    logic        [DATA_W-1:0] th;
    logic        [DATA_W-1:0] ph;
  } red_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } rot_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] len;
    logic                     neg_cos;
    rot_t [LANES-1:0]         lane;
  } crd_t;

  // atan(2^-i) in degrees, scaled by 2^24
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [ROT_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 30'd754974720;
      5'd1:    v = 30'd445687602;
      5'd2:    v = 30'd235489088;
      5'd3:    v = 30'd119537938;
      5'd4:    v = 30'd60000934;
      5'd5:    v = 30'd30029717;
      5'd6:    v = 30'd15018523;
      5'd7:    v = 30'd7509720;
      5'd8:    v = 30'd3754917;
      5'd9:    v = 30'd1877466;
      5'd10:   v = 30'd938734;
      5'd11:   v = 30'd469367;
      5'd12:   v = 30'd234684;
      5'd13:   v = 30'd117342;
      5'd14:   v = 30'd58671;
      5'd15:   v = 30'd29335;
      5'd16:   v = 30'd14668;
      5'd17:   v = 30'd7334;
      5'd18:   v = 30'd3667;
      5'd19:   v = 30'd1833;
      5'd20:   v = 30'd917;
      5'd21:   v = 30'd458;
      5'd22:   v = 30'd229;
      5'd23:   v = 30'd115;
      5'd24:   v = 30'd57;
      5'd25:   v = 30'd29;
      5'd26:   v = 30'd14;
      5'd27:   v = 30'd7;
      5'd28:   v = 30'd4;
      5'd29:   v = 30'd2;
      5'd30:   v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ design/p2c_reduce_cell.sv @@
`default_nettype none

module p2c_reduce_cell import p2c_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [RED_IDX_W-1:0] shift_i,
  input  logic                 valid_i,
  input  red_t                 word_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output red_t                 word_o,
  input  logic                 ready_i
);

  logic [DATA_W-1:0] step;
  logic              v_q;
  red_t              word_q;
  red_t              word_d;

  // Drop one turn times 2^shift when the angle holds at least that much.
  function automatic logic [DATA_W-1:0] trim(input logic [DATA_W-1:0] u,
                                             input logic [DATA_W-1:0] s);
    return (u >= s) ? (u - s) : u;
  endfunction

  assign step    = TURN_Q16 << shift_i;
  assign ready_o = !v_q || ready_i;

  always_comb begin
    word_d     = word_i;
    word_d.th  = trim(word_i.th, step);
    word_d.ph  = trim(word_i.ph, step);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = v_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

@@ design/p2c_cordic_cell.sv @@
`default_nettype none

module p2c_cordic_cell import p2c_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ROT_IDX_W-1:0] stage_i,
  input  logic                 valid_i,
  input  crd_t                 word_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output crd_t                 word_o,
  input  logic                 ready_i
);

  logic signed [DATA_W-1:0] atan_s;
  rot_t                     rot_d [LANES];
  crd_t                     word_d;
  crd_t                     word_q;
  logic                     v_q;

  assign atan_s  = $signed({{(DATA_W-ATAN_W){1'b0}}, atan_deg(stage_i)});
  assign ready_o = !v_q || ready_i;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;

    assign dx = $signed(word_i.lane[l].y) >>> stage_i;
    assign dy = $signed(word_i.lane[l].x) >>> stage_i;

    // Rotate toward zero residual angle.
    always_comb begin
      if (!word_i.lane[l].z[DATA_W-1]) begin
        rot_d[l].x = word_i.lane[l].x - dx;
        rot_d[l].y = word_i.lane[l].y + dy;
        rot_d[l].z = word_i.lane[l].z - atan_s;
      end else begin
        rot_d[l].x = word_i.lane[l].x + dx;
        rot_d[l].y = word_i.lane[l].y - dy;
        rot_d[l].z = word_i.lane[l].z + atan_s;
      end
    end
  end

  always_comb begin
    word_d = word_i;
    for (int l = 0; l < LANES; l++) begin
      word_d.lane[l] = rot_d[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = v_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

@@ design/p2c_scale_cell.sv @@
`default_nettype none

module p2c_scale_cell import p2c_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  crd_t                     word_i,
  output logic                     ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] x_part_o,
  output logic signed [DATA_W-1:0] y_part_o,
  output logic signed [DATA_W-1:0] z_part_o
);

  localparam int unsigned OUTS   = 3;
  localparam int unsigned TRIG_W = DATA_W - 1;
  localparam int unsigned PROD_W = DATA_W + TRIG_W;
  localparam int unsigned FRAC_W = 30;
  localparam logic signed [DATA_W-1:0] TRIG_ONE = 32'sd1073741824;
  localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic signed [DATA_W-1:0] trig [OUTS];
  logic [DATA_W-1:0]        len_mag;

  logic                     v1_q, v2_q, v3_q;
  logic                     r1, r2, r3;

  logic [DATA_W-1:0]        m_q;
  logic [TRIG_W-1:0]        f_d [OUTS];
  logic [TRIG_W-1:0]        f_q [OUTS];
  logic                     neg1_d [OUTS];
  logic                     neg1_q [OUTS];
  logic [PROD_W-1:0]        prod_q [OUTS];
  logic                     neg2_q [OUTS];
  logic [DATA_W-1:0]        res_d [OUTS];
  logic [DATA_W-1:0]        res_q [OUTS];

  function automatic logic signed [DATA_W-1:0] clamp(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > TRIG_ONE) begin
      r = TRIG_ONE;
    end else if (v < -TRIG_ONE) begin
      r = -TRIG_ONE;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign r3      = !v3_q || out_ready_i;
  assign r2      = !v2_q || r3;
  assign r1      = !v1_q || r2;
  assign ready_o = r1;

  always_comb begin
    logic signed [DATA_W-1:0] c;
    c       = clamp(word_i.lane[LANE_TH].x);
    trig[0] = word_i.neg_cos ? -c : c;
    trig[1] = clamp(word_i.lane[LANE_TH].y);
    trig[2] = clamp(word_i.lane[LANE_PH].y);
  end

  assign len_mag = word_i.len[DATA_W-1] ? (~word_i.len + 1'b1) : word_i.len;

  for (genvar k = 0; k < OUTS; k++) begin : g_out
    logic [DATA_W-1:0] tn;
    logic [PROD_W-1:0] sum;
    logic [DATA_W-1:0] mag;

    assign tn        = ~trig[k] + 1'b1;
    assign f_d[k]    = trig[k][DATA_W-1] ? tn[TRIG_W-1:0] : trig[k][TRIG_W-1:0];
    assign neg1_d[k] = word_i.len[DATA_W-1] ^ trig[k][DATA_W-1];

    // Round half away from zero on the magnitude, then saturate.
    assign sum      = prod_q[k] + (PROD_W'(1) << (FRAC_W - 1));
    assign mag      = sum[FRAC_W+DATA_W-1:FRAC_W];
    assign res_d[k] = neg2_q[k] ? (~mag + 1'b1) : (mag[DATA_W-1] ? POS_MAX : mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      m_q <= len_mag;
      for (int k = 0; k < OUTS; k++) begin
        f_q[k]    <= f_d[k];
        neg1_q[k] <= neg1_d[k];
      end
    end
    if (r2 && v1_q) begin
      for (int k = 0; k < OUTS; k++) begin
        prod_q[k] <= {{TRIG_W{1'b0}}, m_q} * {{DATA_W{1'b0}}, f_q[k]};
        neg2_q[k] <= neg1_q[k];
      end
    end
    if (r3 && v2_q) begin
      for (int k = 0; k < OUTS; k++) begin
        res_q[k] <= res_d[k];
      end
    end
  end

  assign out_valid_o = v3_q;
  assign x_part_o    = $signed(res_q[0]);
  assign y_part_o    = $signed(res_q[1]);
  assign z_part_o    = $signed(res_q[2]);

endmodule

`default_nettype wire

@@ design/polar_to_cartesian_degrees.sv @@
// Polar to Cartesian conversion with angles in degrees.
// Input channel (in_valid_i / in_ready_o) carries one word: length_i,
// theta_deg_i and phi_deg_i, all signed Q16.16. Output channel
// (out_valid_o / out_ready_i) returns one word per input word:
// x_part_o = length*cos(theta), y_part_o = length*sin(theta) and
// z_part_o = length*sin(phi), signed Q16.16, rounded and saturated.
// The pipe holds 1 wrap stage, 7 modulo-360 cells, 1 fold stage,
// 18 rotation cells and 3 scale stages (magnitude, multiply, round).
// Throughput is one word per cycle; every stage is a cell with its own
// valid bit, so a word can enter each cycle while the pipe flows.
// When the receiver stalls, words pile into empty cells from the back
// and in_ready_o falls only once every cell holds a word.
// Reset clears all valid bits; the pipe is empty and ready right after.
// Words leave in the order they arrived.

`default_nettype none

module polar_to_cartesian_degrees import p2c_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DATA_W-1:0] length_i,
  input  logic signed [DATA_W-1:0] theta_deg_i,
  input  logic signed [DATA_W-1:0] phi_deg_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] x_part_o,
  output logic signed [DATA_W-1:0] y_part_o,
  output logic signed [DATA_W-1:0] z_part_o
);

  // A multiple of a full turn that lifts any negative angle above zero
  // while staying below 2^RED_CELLS turns.
  localparam logic [DATA_W-1:0] WRAP_OFS  = TURN_Q16 << RED_CELLS;
  localparam logic [DATA_W-1:0] QUARTER   = 32'd5898240;
  localparam logic [DATA_W-1:0] HALF      = 32'd11796480;
  localparam logic [DATA_W-1:0] THREE_Q   = 32'd17694720;
  localparam int unsigned       DEG_SHIFT = 8;

  typedef struct packed {
    logic                     neg;
    logic signed [DATA_W-1:0] z;
  } fold_t;

  // Entry stage: wrap negatives up by whole turns.
  logic  ent_v_q;
  logic  ent_rdy;
  red_t  ent_d;
  red_t  ent_q;

  // Modulo-360 chain.
  logic  red_v [RED_CELLS+1];
  red_t  red_w [RED_CELLS+1];
  logic  red_r [RED_CELLS+1];

  // Fold stage: bring the angle into [-90, 90] and seed the rotation.
  logic  fold_v_q;
  logic  fold_rdy;
  fold_t fold_th;
  fold_t fold_ph;
  crd_t  fold_d;
  crd_t  fold_q;

  // Rotation chain.
  logic  crd_v [ROT_STAGES+1];
  crd_t  crd_w [ROT_STAGES+1];
  logic  crd_r [ROT_STAGES+1];

  // Map an angle in [0, 360) degrees, Q16.16, onto [-90, 90] degrees
  // scaled by 2^24; flag where cosine changes sign.
  function automatic fold_t fold_angle(input logic [DATA_W-1:0] a);
    fold_t             r;
    logic [DATA_W-1:0] v;
    if (a <= QUARTER) begin
      v     = a;
      r.neg = 1'b0;
    end else if (a < THREE_Q) begin
      v     = HALF - a;
      r.neg = 1'b1;
    end else begin
      v     = a - TURN_Q16;
      r.neg = 1'b0;
    end
    r.z = $signed(v << DEG_SHIFT);
    return r;
  endfunction

  // Entry stage
  assign ent_rdy    = !ent_v_q || red_r[0];
  assign in_ready_o = ent_rdy;

  always_comb begin
    ent_d.len = length_i;
    ent_d.th  = theta_deg_i[DATA_W-1] ? (theta_deg_i + WRAP_OFS) : theta_deg_i;
    ent_d.ph  = phi_deg_i[DATA_W-1]   ? (phi_deg_i + WRAP_OFS)   : phi_deg_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
    end else if (ent_rdy) begin
      ent_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_rdy && in_valid_i) begin
      ent_q <= ent_d;
    end
  end

  assign red_v[0] = ent_v_q;
  assign red_w[0] = ent_q;

  // Take off 2^k turns in cell order k = RED_CELLS-1 down to 0.
  for (genvar j = 0; j < RED_CELLS; j++) begin : g_red
    p2c_reduce_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (RED_IDX_W'(RED_CELLS - 1 - j)),
      .valid_i (red_v[j]),
      .word_i  (red_w[j]),
      .ready_o (red_r[j]),
      .valid_o (red_v[j+1]),
      .word_o  (red_w[j+1]),
      .ready_i (red_r[j+1])
    );
  end

  // Fold stage
  assign fold_rdy          = !fold_v_q || crd_r[0];
  assign red_r[RED_CELLS]  = fold_rdy;
  assign fold_th           = fold_angle(red_w[RED_CELLS].th);
  assign fold_ph           = fold_angle(red_w[RED_CELLS].ph);

  always_comb begin
    fold_d.len             = red_w[RED_CELLS].len;
    fold_d.neg_cos         = fold_th.neg;
    fold_d.lane[LANE_TH].x = GAIN_INV;
    fold_d.lane[LANE_TH].y = '0;
    fold_d.lane[LANE_TH].z = fold_th.z;
    fold_d.lane[LANE_PH].x = GAIN_INV;
    fold_d.lane[LANE_PH].y = '0;
    fold_d.lane[LANE_PH].z = fold_ph.z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_v_q <= 1'b0;
    end else if (fold_rdy) begin
      fold_v_q <= red_v[RED_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fold_rdy && red_v[RED_CELLS]) begin
      fold_q <= fold_d;
    end
  end

  assign crd_v[0] = fold_v_q;
  assign crd_w[0] = fold_q;

  // One rotation step per cell, both angles side by side.
  for (genvar i = 0; i < ROT_STAGES; i++) begin : g_rot
    p2c_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (ROT_IDX_W'(i)),
      .valid_i (crd_v[i]),
      .word_i  (crd_w[i]),
      .ready_o (crd_r[i]),
      .valid_o (crd_v[i+1]),
      .word_o  (crd_w[i+1]),
      .ready_i (crd_r[i+1])
    );
  end

  // Clamp, multiply by length, round and saturate; last stage is the
  // output register.
  p2c_scale_cell u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (crd_v[ROT_STAGES]),
    .word_i      (crd_w[ROT_STAGES]),
    .ready_o     (crd_r[ROT_STAGES]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .x_part_o    (x_part_o),
    .y_part_o    (y_part_o),
    .z_part_o    (z_part_o)
  );

endmodule

`default_nettype wire

@@ tb/tb_p2c_scoreboard_pkg.sv @@
package tb_p2c_scoreboard_pkg;

  import p2c_pkg::DATA_W;
  import p2c_pkg::ROT_STAGES;
  import p2c_pkg::rot_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] len;
    logic signed [DATA_W-1:0] th;
    logic signed [DATA_W-1:0] ph;
  } polar_t;

  localparam longint DEG_Q24      = 64'sd16777216;
  localparam longint TURN_Q16     = 64'sd23592960;
  localparam longint UNIT_Q30     = 64'sd1073741824;
  localparam longint GAIN_INV_Q30 = 64'sd652032874;
  localparam int     MAX_PRINTED  = 40;

  // atan(2^-i) in degrees, Q8.24
  localparam longint ATAN_Q24 [32] = '{
    754974720, 445687602, 235489088, 119537938,
    60000934, 30029717, 15018523, 7509720,
    3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335,
    14668, 7334, 3667, 1833,
    917, 458, 229, 115,
    57, 29, 14, 7,
    4, 2, 1, 0
  };

  class p2c_scoreboard;
    rot_t        expected_q[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    // Sine and cosine of a Q16.16 degree angle, both Q2.30.
    static function void sin_cos_deg(input longint ang, output longint sn, output longint cs);
      longint a;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      bit     neg_cos;
      int     n;
      int     i;
      a = ang % TURN_Q16;
      if (a < 0) a += TURN_Q16;
      a = a * 256;
      if (a > 180 * DEG_Q24) a -= 360 * DEG_Q24;
      neg_cos = 1'b0;
      // Fold into [-90, 90]; the cosine flips sign, the sine does not.
      if (a > 90 * DEG_Q24) begin
        a = 180 * DEG_Q24 - a;
        neg_cos = 1'b1;
      end else if (a < -90 * DEG_Q24) begin
        a = -180 * DEG_Q24 - a;
        neg_cos = 1'b1;
      end
      x = GAIN_INV_Q30;
      y = 0;
      z = a;
      n = (ROT_STAGES > 32) ? 32 : int'(ROT_STAGES);
      for (i = 0; i < n; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= ATAN_Q24[i];
        end else begin
          x += dx;
          y -= dy;
          z += ATAN_Q24[i];
        end
      end
      if (x > UNIT_Q30) x = UNIT_Q30;
      if (x < -UNIT_Q30) x = -UNIT_Q30;
      if (y > UNIT_Q30) y = UNIT_Q30;
      if (y < -UNIT_Q30) y = -UNIT_Q30;
      sn = y;
      cs = neg_cos ? -x : x;
    endfunction

    // Q16.16 length times Q2.30 trig value, rounded half away from zero, saturated.
    static function logic signed [DATA_W-1:0] scale_by_length(input longint len, input longint t);
      bit          neg;
      bit [63:0]   m;
      bit [63:0]   f;
      bit [63:0]   a;
      bit [63:0]   b;
      bit [63:0]   mag;
      bit [63:0]   hi;
      longint      r;
      longint      lo;
      neg = (len < 0) != (t < 0);
      m   = (len < 0) ? -len : len;
      f   = (t < 0) ? -t : t;
      a   = (m >> 16) * f;
      b   = (m & 64'hFFFF) * f + (64'd1 << 29);
      mag = (a >> 14) + ((((a & 64'h3FFF) << 16) + b) >> 30);
      hi  = (64'd1 << (DATA_W - 1)) - 64'd1;
      lo  = -longint'(hi) - 1;
      if (mag > hi + 64'd1) mag = hi + 64'd1;
      if (neg) r = -longint'(mag);
      else r = (mag > hi) ? longint'(hi) : longint'(mag);
      if (r < lo) r = lo;
      return r[DATA_W-1:0];
    endfunction

    // Queue the converted triple for an accepted input word.
    function void note_word(input polar_t w);
      longint st;
      longint ct;
      longint sp;
      longint cp;
      rot_t   e;
      sin_cos_deg(longint'(w.th), st, ct);
      sin_cos_deg(longint'(w.ph), sp, cp);
      e.x = scale_by_length(longint'(w.len), ct);
      e.y = scale_by_length(longint'(w.len), st);
      e.z = scale_by_length(longint'(w.len), sp);
      expected_q.push_back(e);
    endfunction

    task report(input string what, input logic [DATA_W-1:0] got, input logic [DATA_W-1:0] want);
      if (errors < MAX_PRINTED)
        $display("mismatch on %s, output word %0d: got %h, want %h", what, checked, got, want);
      errors++;
    endtask

    task check_word(input rot_t got);
      rot_t want;
      if (expected_q.size() == 0) begin
        report("unexpected word", got.x, got.x);
      end else begin
        want = expected_q.pop_front();
        if (got.x !== want.x) report("x_part", got.x, want.x);
        if (got.y !== want.y) report("y_part", got.y, want.y);
        if (got.z !== want.z) report("z_part", got.z, want.z);
      end
      checked++;
    endtask
  endclass

endpackage

@@ tb/tb_polar_to_cartesian_degrees.sv @@
module tb_polar_to_cartesian_degrees;

  timeunit 1ns;
  timeprecision 1ps;

  import p2c_pkg::DATA_W;
  import p2c_pkg::rot_t;
  import tb_p2c_scoreboard_pkg::*;

  localparam int unsigned RANDOM_WORDS = 700;
  // Pipe is 30 deep; give the tail some margin after the queue drains.
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          Q16_ONE      = 65536;
  localparam logic signed [DATA_W-1:0] LEN_MAX = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] LEN_MIN = 32'sh80000000;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DATA_W-1:0] length;
  logic signed [DATA_W-1:0] theta;
  logic signed [DATA_W-1:0] phi;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] x_part;
  logic signed [DATA_W-1:0] y_part;
  logic signed [DATA_W-1:0] z_part;

  int unsigned   cycle_count = 0;
  p2c_scoreboard sb = new();

  always #4 clk = ~clk;

  polar_to_cartesian_degrees uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .length_i    (length),
    .theta_deg_i (theta),
    .phi_deg_i   (phi),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .x_part_o    (x_part),
    .y_part_o    (y_part),
    .z_part_o    (z_part)
  );

  // Watchdog: drop the run if the pipe hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Sample the output side at the rising edge, before the pipe advances.
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_ready === 1'b1)
      sb.check_word(rot_t'{x_part, y_part, z_part});
  end

  // Receiver back-pressure: switch among random stall modes so that
  // stalls land on every pipe phase, with free-flowing stretches in between.
  initial begin
    int unsigned stall_mode;
    int unsigned phase;
    out_ready  = 1'b0;
    stall_mode = 0;
    phase      = 0;
    forever begin
      @(negedge clk);
      if (phase % 48 == 0) stall_mode = $urandom_range(0, 4);
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ((phase % 16) < 4);
        3:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ((phase % 40) >= 34);
      endcase
      phase++;
    end
  end

  function automatic logic signed [DATA_W-1:0] deg_q16(input int d);
    return d * Q16_ONE;
  endfunction

  // Present one word at the falling edge and hold it until it is taken.
  task automatic send_word(input polar_t w);
    @(negedge clk);
    in_valid <= 1'b1;
    length   <= w.len;
    theta    <= w.th;
    phi      <= w.ph;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Angles: full 32-bit range, a few turns either way, near right angles, one turn.
  function automatic logic signed [DATA_W-1:0] rand_angle();
    logic signed [DATA_W-1:0] a;
    case ($urandom_range(0, 3))
      0:       a = $urandom;
      1:       a = int'($urandom_range(0, 1440 * Q16_ONE)) - 720 * Q16_ONE;
      2:       a = deg_q16(90 * (int'($urandom_range(0, 80)) - 40))
                   + int'($urandom_range(0, 8)) - 4;
      default: a = $urandom_range(0, 360 * Q16_ONE - 1);
    endcase
    return a;
  endfunction

  function automatic polar_t rand_word();
    polar_t w;
    case ($urandom_range(0, 4))
      0:       w.len = int'($urandom_range(0, 1 << 20)) * ($urandom_range(0, 1) ? 1 : -1);
      1:       w.len = $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0:       w.len = LEN_MAX;
          1:       w.len = LEN_MIN;
          2:       w.len = 1;
          3:       w.len = -1;
          default: w.len = 0;
        endcase
      end
      default: w.len = int'($urandom_range(0, 1 << 25)) - (1 << 24);
    endcase
    w.th = rand_angle();
    w.ph = rand_angle();
    return w;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    length   = '0;
    theta    = '0;
    phi      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words: right angles and full turns, wrap of negative and
    // large angles, fold boundaries, negative length, overflow corners.
    send_word(polar_t'{deg_q16(1), deg_q16(0), deg_q16(90)});
    send_word(polar_t'{deg_q16(1), deg_q16(90), deg_q16(-90)});
    send_word(polar_t'{deg_q16(1), deg_q16(180), deg_q16(270)});
    send_word(polar_t'{deg_q16(1), deg_q16(270), deg_q16(360)});
    send_word(polar_t'{deg_q16(1), deg_q16(360), deg_q16(-360)});
    send_word(polar_t'{deg_q16(1), deg_q16(-90), deg_q16(180)});
    send_word(polar_t'{deg_q16(1), deg_q16(45), deg_q16(30)});
    send_word(polar_t'{deg_q16(100), deg_q16(30), deg_q16(60)});
    send_word(polar_t'{deg_q16(-1), deg_q16(60), deg_q16(45)});
    send_word(polar_t'{32'sd0, deg_q16(123), deg_q16(77)});
    send_word(polar_t'{32'sd1, deg_q16(0), deg_q16(90)});
    send_word(polar_t'{-32'sd1, deg_q16(180), deg_q16(-90)});
    send_word(polar_t'{LEN_MAX, deg_q16(0), deg_q16(90)});
    send_word(polar_t'{LEN_MAX, deg_q16(180), deg_q16(270)});
    send_word(polar_t'{LEN_MIN, deg_q16(0), deg_q16(90)});
    send_word(polar_t'{LEN_MIN, deg_q16(180), deg_q16(-90)});
    send_word(polar_t'{LEN_MAX, 32'sh7FFFFFFF, 32'sh80000000});
    send_word(polar_t'{LEN_MIN, 32'sh80000000, 32'sh7FFFFFFF});
    send_word(polar_t'{deg_q16(2) + 32768, deg_q16(90) + 1, deg_q16(90) - 1});
    send_word(polar_t'{deg_q16(2) + 32768, deg_q16(180) + 1, deg_q16(-180)});
    send_word(polar_t'{deg_q16(1000), deg_q16(720) + 32768, deg_q16(-450)});
    send_word(polar_t'{deg_q16(32767), deg_q16(135), deg_q16(225)});
    send_word(polar_t'{32'sh55555555, 32'shAAAAAAAA, 32'sh33333333});
    send_word(polar_t'{32'shAAAAAAAA, 32'sh55555555, 32'shCCCCCCCC});

    // Random words in bursts; now and then a long burst with no gap at all.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 5) == 0) begin
        burst = $urandom_range(30, 60);
        gap   = 0;
      end else begin
        burst = $urandom_range(1, 20);
        gap   = $urandom_range(0, 12);
      end
      repeat (burst) begin
        send_word(rand_word());
        sent++;
      end
      idle_cycles(gap);
    end
    idle_cycles(1);

    // Drain: wait for every pending word, then let stray ones show up.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
